FILE: rtl/core/lcr_pkg.sv
package lcr_pkg;

  // Default sizing, handed down through the top-level parameters
  localparam int unsigned DefSampleBits      = 24;
  localparam int unsigned DefZeroAverageCnt  = 100;
  localparam int unsigned DefMaxTareCount    = 1024;

  localparam int unsigned QueueDepth         = 2;

  localparam int unsigned ValueW             = 24;
  localparam int unsigned WeightW            = 16;
  localparam int unsigned ScaleW             = 32;
  localparam int unsigned TareCountW         = 11;
  localparam int unsigned GainW              = 2;
  localparam int unsigned FracBits           = 16;

  // Configuration register map (word indices, decoded from paddr[3:2])
  localparam int unsigned AddrW              = 4;
  localparam logic [1:0]  RegGainPulses      = 2'd0;
  localparam logic [1:0]  RegScaleFactor     = 2'd1;
  localparam logic [1:0]  RegTareCount       = 2'd2;

  localparam logic [GainW-1:0]      GainPulsesReset  = 2'd1;
  localparam logic [ScaleW-1:0]     ScaleFactorReset = 32'd65536;
  localparam logic [TareCountW-1:0] TareCountReset   = 11'd16;

  // Mode codes of an input request
  localparam logic [1:0] ModeTick = 2'd0;
  localparam logic [1:0] ModeTare = 2'd1;
  localparam logic [1:0] ModeZero = 2'd2;

  // Averaging run kinds
  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindTare = 2'd1;
  localparam logic [1:0] KindZero = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DATA = 3'b010,
    PH_GAIN = 3'b100
  } phase_e;

  typedef enum logic [4:0] {
    BK_IDLE = 5'b00001,
    BK_MUL  = 5'b00010,
    BK_FIN  = 5'b00100,
    BK_DIV  = 5'b01000,
    BK_EMIT = 5'b10000
  } bstate_e;

  // Per-tick control info passed from the front end to the back end
  typedef struct packed {
    logic       clk_level;
    logic       sample;
    logic [1:0] mode;
  } tick_ctrl_t;

endpackage

FILE: rtl/core/load_cell_adc_serial_reader_unit.sv
// A tick request passes through the front end and the request queue to the
// back end: MUL and FIN for a finished sample, the bit-serial divider when the
// tick completes an averaging run, then the result register. The back end
// handles one tick at a time; the two-entry queue takes more until full.
// Reset (rst_ni, async low): converter idle, offsets zero, no run active,
// registers gain_pulses 1, scale_factor 1.0 (Q16.16), tare_count 16.
module load_cell_adc_serial_reader_unit #(
  parameter int unsigned SAMPLE_BITS        = lcr_pkg::DefSampleBits,
  parameter int unsigned ZERO_AVERAGE_COUNT = lcr_pkg::DefZeroAverageCnt,
  parameter int unsigned MAX_TARE_COUNT     = lcr_pkg::DefMaxTareCount
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      mode_i,
  input  logic                            data_pin_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            serial_clock_o,
  output logic                            sample_valid_o,
  output logic [lcr_pkg::ValueW-1:0]      sample_value_o,
  output logic [lcr_pkg::WeightW-1:0]     weight_o,
  output logic                            calibrating_o,
  output logic                            calibration_done_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcr_pkg::AddrW-1:0]       paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned CtrlW = $bits(lcr_pkg::tick_ctrl_t);
  localparam int unsigned QW    = CtrlW + SAMPLE_BITS;

  logic [lcr_pkg::GainW-1:0]      gain_q;
  logic [lcr_pkg::ScaleW-1:0]     scale_q;
  logic [lcr_pkg::TareCountW-1:0] tare_cnt_q;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= lcr_pkg::GainPulsesReset;
      scale_q    <= lcr_pkg::ScaleFactorReset;
      tare_cnt_q <= lcr_pkg::TareCountReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lcr_pkg::RegGainPulses:  gain_q     <= pwdata[lcr_pkg::GainW-1:0];
        lcr_pkg::RegScaleFactor: scale_q    <= pwdata;
        lcr_pkg::RegTareCount:   tare_cnt_q <= pwdata[lcr_pkg::TareCountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lcr_pkg::RegGainPulses:  prdata = 32'(gain_q);
      lcr_pkg::RegScaleFactor: prdata = scale_q;
      lcr_pkg::RegTareCount:   prdata = 32'(tare_cnt_q);
      default:                 prdata = '0;
    endcase
  end

  lcr_pkg::tick_ctrl_t     f_ctrl, b_ctrl;
  logic [SAMPLE_BITS-1:0]  f_word, b_word;
  logic                    take, q_full, q_empty, q_pop;
  logic [QW-1:0]           q_rdata;

  assign take       = in_valid_i && !q_full;
  assign in_stall_o = q_full;

  lcr_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .data_pin_i    (data_pin_i),
    .mode_i        (mode_i),
    .gain_pulses_i (gain_q),
    .ctrl_o        (f_ctrl),
    .word_o        (f_word)
  );

  lcr_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .push_data_i ({f_ctrl, f_word}),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  assign b_ctrl = q_rdata[QW-1:SAMPLE_BITS];
  assign b_word = q_rdata[SAMPLE_BITS-1:0];

  lcr_back #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .ZERO_AVERAGE_COUNT (ZERO_AVERAGE_COUNT),
    .MAX_TARE_COUNT     (MAX_TARE_COUNT)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .empty_i            (q_empty),
    .pop_o              (q_pop),
    .ctrl_i             (b_ctrl),
    .word_i             (b_word),
    .scale_factor_i     (scale_q),
    .tare_count_i       (tare_cnt_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .serial_clock_o     (serial_clock_o),
    .sample_valid_o     (sample_valid_o),
    .sample_value_o     (sample_value_o),
    .weight_o           (weight_o),
    .calibrating_o      (calibrating_o),
    .calibration_done_o (calibration_done_o)
  );

endmodule

FILE: rtl/core/lcr_front.sv
module lcr_front #(
  parameter int unsigned SAMPLE_BITS = lcr_pkg::DefSampleBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         take_i,
  input  logic                         data_pin_i,
  input  logic [1:0]                   mode_i,
  input  logic [lcr_pkg::GainW-1:0]    gain_pulses_i,
  output lcr_pkg::tick_ctrl_t          ctrl_o,
  output logic [SAMPLE_BITS-1:0]       word_o
);

  localparam int unsigned PCW = $clog2(SAMPLE_BITS + 1);
  localparam logic [SAMPLE_BITS-1:0] MsbMask = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  lcr_pkg::phase_e          phase_q, phase_d;
  logic                     clk_q, clk_d;
  logic [PCW-1:0]           cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0]   shift_q, shift_d;
  logic                     sample;
  logic [PCW-1:0]           cnt_inc;
  logic [PCW-1:0]           gain_eff;

  assign cnt_inc  = cnt_q + PCW'(1);
  // a gain setting of zero behaves as one pulse
  assign gain_eff = (gain_pulses_i == '0) ? PCW'(1) : PCW'(gain_pulses_i);

  always_comb begin
    phase_d = phase_q;
    clk_d   = clk_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    sample  = 1'b0;
    case (phase_q)
      lcr_pkg::PH_IDLE: begin
        clk_d = 1'b0;
        if (!data_pin_i) begin
          phase_d = lcr_pkg::PH_DATA;
          cnt_d   = '0;
          shift_d = '0;
        end
      end
      lcr_pkg::PH_DATA: begin
        if (!clk_q) begin
          clk_d = 1'b1;
        end else begin
          clk_d   = 1'b0;
          shift_d = {shift_q[SAMPLE_BITS-2:0], data_pin_i};
          if (cnt_inc >= PCW'(SAMPLE_BITS)) begin
            phase_d = lcr_pkg::PH_GAIN;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      lcr_pkg::PH_GAIN: begin
        if (!clk_q) begin
          clk_d = 1'b1;
        end else begin
          clk_d = 1'b0;
          if (cnt_inc >= gain_eff) begin
            sample  = 1'b1;
            phase_d = lcr_pkg::PH_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      default: begin
        phase_d = lcr_pkg::PH_IDLE;
        clk_d   = 1'b0;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lcr_pkg::PH_IDLE;
      clk_q   <= 1'b0;
      cnt_q   <= '0;
      shift_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      clk_q   <= clk_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
    end
  end

  assign ctrl_o.clk_level = clk_d;
  assign ctrl_o.sample    = sample;
  assign ctrl_o.mode      = mode_i;
  // two's complement to offset binary (unsigned)
  assign word_o           = shift_q ^ MsbMask;

endmodule

FILE: rtl/core/lcr_queue.sv
module lcr_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned Depth = lcr_pkg::QueueDepth;
  localparam int unsigned IW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [IW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    count_q;

  assign full_o     = (count_q == CW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == IW'(Depth - 1)) ? '0 : wr_q + IW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == IW'(Depth - 1)) ? '0 : rd_q + IW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/lcr_back.sv
module lcr_back #(
  parameter int unsigned SAMPLE_BITS        = lcr_pkg::DefSampleBits,
  parameter int unsigned ZERO_AVERAGE_COUNT = lcr_pkg::DefZeroAverageCnt,
  parameter int unsigned MAX_TARE_COUNT     = lcr_pkg::DefMaxTareCount
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              empty_i,
  output logic                              pop_o,
  input  lcr_pkg::tick_ctrl_t               ctrl_i,
  input  logic [SAMPLE_BITS-1:0]            word_i,
  input  logic [lcr_pkg::ScaleW-1:0]        scale_factor_i,
  input  logic [lcr_pkg::TareCountW-1:0]    tare_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              serial_clock_o,
  output logic                              sample_valid_o,
  output logic [lcr_pkg::ValueW-1:0]        sample_value_o,
  output logic [lcr_pkg::WeightW-1:0]       weight_o,
  output logic                              calibrating_o,
  output logic                              calibration_done_o
);

  localparam int unsigned VLW    = lcr_pkg::ValueW;
  localparam int unsigned VW     = (SAMPLE_BITS > VLW) ? SAMPLE_BITS : VLW;
  localparam int unsigned MaxAvg = (MAX_TARE_COUNT > ZERO_AVERAGE_COUNT) ?
                                   MAX_TARE_COUNT : ZERO_AVERAGE_COUNT;
  localparam int unsigned CNT_W  = $clog2(MaxAvg + 1);
  localparam int unsigned TW     = (CNT_W > lcr_pkg::TareCountW) ? CNT_W : lcr_pkg::TareCountW;
  localparam int unsigned SUM_W  = VLW + CNT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);
  localparam int unsigned PW     = VLW + lcr_pkg::ScaleW;
  localparam int unsigned WW     = lcr_pkg::WeightW;
  localparam int unsigned FB     = lcr_pkg::FracBits;

  lcr_pkg::bstate_e     state_q;
  logic                 clk_lvl_q, smp_q, done_q;
  logic [VLW-1:0]       sv_q;
  logic [WW-1:0]        wt_q;
  logic [PW-1:0]        prod_q;
  logic [1:0]           kind_q;
  logic [SUM_W-1:0]     sum_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [VLW-1:0]       zero_q, tare_q;
  logic [CNT_W-1:0]     div_q, rem_q;
  logic [SUM_W-1:0]     quo_q;
  logic [STEP_W-1:0]    step_q;

  logic                 out_valid_q;
  logic                 out_clk_q, out_smp_q, out_cal_q, out_done_q;
  logic [VLW-1:0]       out_sv_q;
  logic [WW-1:0]        out_wt_q;

  // sample minus zero offset, clamped
  logic [VW-1:0]        v_ext, z_ext, r_val;
  logic [VLW-1:0]       sv_new;
  always_comb begin
    v_ext  = VW'(word_i);
    z_ext  = VW'(zero_q);
    r_val  = (v_ext > z_ext) ? (v_ext - z_ext) : '0;
    sv_new = (r_val > VW'({VLW{1'b1}})) ? {VLW{1'b1}} : r_val[VLW-1:0];
  end

  logic [VLW-1:0]       diff;
  assign diff = (sv_q > tare_q) ? (sv_q - tare_q) : '0;

  logic [WW-1:0]        wt_sat;
  assign wt_sat = (prod_q[PW-1:FB] > (PW-FB)'({WW{1'b1}})) ? {WW{1'b1}} : prod_q[FB+WW-1:FB];

  // averaging target; tare count is clamped to 1..MAX_TARE_COUNT
  logic [TW-1:0]        tare_ext;
  logic [CNT_W-1:0]     target, cnt_inc;
  always_comb begin
    tare_ext = TW'(tare_count_i);
    if (tare_ext == '0) begin
      tare_ext = TW'(1);
    end else if (tare_ext > TW'(MAX_TARE_COUNT)) begin
      tare_ext = TW'(MAX_TARE_COUNT);
    end
    target = (kind_q == lcr_pkg::KindTare) ? CNT_W'(tare_ext) : CNT_W'(ZERO_AVERAGE_COUNT);
  end
  assign cnt_inc = cnt_q + CNT_W'(1);

  logic [SUM_W-1:0]     sum_next;
  assign sum_next = sum_q + SUM_W'(sv_q);

  // one restoring division step a cycle
  logic [CNT_W:0]       trial;
  logic                 ge;
  logic [CNT_W-1:0]     rem_n;
  logic [SUM_W-1:0]     quo_n;
  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    ge    = (trial >= {1'b0, div_q});
    rem_n = ge ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
    quo_n = {quo_q[SUM_W-2:0], ge};
  end

  logic emit;
  assign emit  = (state_q == lcr_pkg::BK_EMIT) && (!out_valid_q || !out_stall_i);
  assign pop_o = (state_q == lcr_pkg::BK_IDLE) && !empty_i;

  always_ff @(posedge clk_i) begin
    if (state_q == lcr_pkg::BK_MUL) begin
      prod_q <= PW'(diff) * PW'(scale_factor_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lcr_pkg::BK_IDLE;
      clk_lvl_q <= 1'b0;
      smp_q     <= 1'b0;
      done_q    <= 1'b0;
      sv_q      <= '0;
      wt_q      <= '0;
      kind_q    <= lcr_pkg::KindNone;
      sum_q     <= '0;
      cnt_q     <= '0;
      zero_q    <= '0;
      tare_q    <= '0;
      div_q     <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      step_q    <= '0;
    end else begin
      case (state_q)
        lcr_pkg::BK_IDLE: begin
          if (!empty_i) begin
            // a command restarts the run before this tick's sample counts
            if (ctrl_i.mode == lcr_pkg::ModeTare) begin
              kind_q <= lcr_pkg::KindTare;
              sum_q  <= '0;
              cnt_q  <= '0;
            end else if (ctrl_i.mode == lcr_pkg::ModeZero) begin
              kind_q <= lcr_pkg::KindZero;
              sum_q  <= '0;
              cnt_q  <= '0;
            end
            clk_lvl_q <= ctrl_i.clk_level;
            smp_q     <= ctrl_i.sample;
            done_q    <= 1'b0;
            sv_q      <= ctrl_i.sample ? sv_new : '0;
            wt_q      <= '0;
            state_q   <= ctrl_i.sample ? lcr_pkg::BK_MUL : lcr_pkg::BK_EMIT;
          end
        end
        lcr_pkg::BK_MUL: begin
          state_q <= lcr_pkg::BK_FIN;
        end
        lcr_pkg::BK_FIN: begin
          wt_q <= wt_sat;
          if (kind_q != lcr_pkg::KindNone) begin
            if (cnt_inc >= target) begin
              div_q   <= cnt_inc;
              rem_q   <= '0;
              quo_q   <= sum_next;
              step_q  <= '0;
              state_q <= lcr_pkg::BK_DIV;
            end else begin
              sum_q   <= sum_next;
              cnt_q   <= cnt_inc;
              state_q <= lcr_pkg::BK_EMIT;
            end
          end else begin
            state_q <= lcr_pkg::BK_EMIT;
          end
        end
        lcr_pkg::BK_DIV: begin
          rem_q  <= rem_n;
          quo_q  <= quo_n;
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(SUM_W - 1)) begin
            if (kind_q == lcr_pkg::KindTare) begin
              tare_q <= quo_n[VLW-1:0];
            end else begin
              zero_q <= quo_n[VLW-1:0];
            end
            kind_q  <= lcr_pkg::KindNone;
            sum_q   <= '0;
            cnt_q   <= '0;
            done_q  <= 1'b1;
            state_q <= lcr_pkg::BK_EMIT;
          end
        end
        lcr_pkg::BK_EMIT: begin
          if (emit) begin
            state_q <= lcr_pkg::BK_IDLE;
          end
        end
        default: begin
          state_q <= lcr_pkg::BK_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_clk_q  <= clk_lvl_q;
      out_smp_q  <= smp_q;
      out_sv_q   <= sv_q;
      out_wt_q   <= wt_q;
      out_cal_q  <= (kind_q != lcr_pkg::KindNone);
      out_done_q <= done_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign serial_clock_o     = out_clk_q;
  assign sample_valid_o     = out_smp_q;
  assign sample_value_o     = out_sv_q;
  assign weight_o           = out_wt_q;
  assign calibrating_o      = out_cal_q;
  assign calibration_done_o = out_done_q;

endmodule
